FILE: hw/rtl/usbrh_pkg.sv
// ----------------------------------------------------------------------------
// usbrh_pkg
// Shared types, constants and lookup functions for the root hub responder.
// ----------------------------------------------------------------------------
package usbrh_pkg;

	localparam int unsigned S_TDATA_W = 56;
	localparam int unsigned M_TDATA_W = 32;
	localparam int unsigned M_TUSER_W = 3;
	localparam int unsigned IDX_W     = 4;

	localparam logic [2:0] KIND_CLR  = 3'd0;
	localparam logic [2:0] KIND_SET  = 3'd1;
	localparam logic [2:0] KIND_DESC = 3'd2;
	localparam logic [2:0] KIND_STAT = 3'd3;
	localparam logic [2:0] KIND_NOP  = 3'd4;
	localparam logic [2:0] KIND_ERR  = 3'd5;

	localparam logic [7:0] RT_PORT_CLASS = 8'h23;
	localparam logic [7:0] RT_PORT_READ  = 8'hA3;
	localparam logic [7:0] RT_HUB_READ   = 8'hA0;

	localparam logic [7:0] RQ_GET_STATUS     = 8'd0;
	localparam logic [7:0] RQ_CLEAR_FEATURE  = 8'd1;
	localparam logic [7:0] RQ_GET_STATE      = 8'd2;
	localparam logic [7:0] RQ_SET_FEATURE    = 8'd3;
	localparam logic [7:0] RQ_SET_ADDRESS    = 8'd5;
	localparam logic [7:0] RQ_GET_DESCRIPTOR = 8'd6;
	localparam logic [7:0] RQ_SET_DESCRIPTOR = 8'd7;
	localparam logic [7:0] RQ_GET_CONFIG     = 8'd8;
	localparam logic [7:0] RQ_SET_CONFIG     = 8'd9;
	localparam logic [7:0] RQ_GET_INTERFACE  = 8'd10;
	localparam logic [7:0] RQ_SET_INTERFACE  = 8'd11;
	localparam logic [7:0] RQ_SYNCH_FRAME    = 8'd12;

	localparam logic [15:0] FEAT_ENABLE      = 16'd1;
	localparam logic [15:0] FEAT_SUSPEND     = 16'd2;
	localparam logic [15:0] FEAT_RESET       = 16'd4;
	localparam logic [15:0] FEAT_CONN_CHANGE = 16'd16;
	localparam logic [15:0] FEAT_EN_CHANGE   = 16'd17;

	localparam logic [15:0] WC_MASK  = 16'hFFF5;
	localparam logic [15:0] BIT_CSC  = 16'h0002;
	localparam logic [15:0] BIT_PED  = 16'h0004;
	localparam logic [15:0] BIT_PEDC = 16'h0008;
	localparam logic [15:0] BIT_PR   = 16'h0200;
	localparam logic [15:0] BIT_SUSP = 16'h1000;

	localparam logic [3:0] LEN_STATUS = 4'd4;
	localparam logic [3:0] LEN_DESC   = 4'd9;

	typedef struct packed {
		logic        port_write;
		logic        port_number;
		logic [15:0] port_value;
		logic        reply_valid;
		logic [7:0]  reply_byte;
		logic [3:0]  reply_length;
		logic        request_error;
		logic        last_result;
	} result_t;

	function automatic logic [7:0] hub_desc_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'd9;
			4'd1: b = 8'h29;
			4'd2: b = 8'd2;
			4'd3: b = 8'h09;
			4'd4: b = 8'h00;
			4'd5: b = 8'd1;
			4'd6: b = 8'd100;
			4'd7: b = 8'h00;
			4'd8: b = 8'hFF;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// standard and hub requests that are taken but do nothing
	function automatic logic is_nop(input logic [7:0] t, input logic [7:0] r);
		logic ok;
		case (t)
			8'h00: ok = (r == RQ_CLEAR_FEATURE) || (r == RQ_SET_ADDRESS) ||
				(r == RQ_SET_DESCRIPTOR) || (r == RQ_SET_CONFIG) ||
				(r == RQ_SET_FEATURE);
			8'h01: ok = (r == RQ_CLEAR_FEATURE) || (r == RQ_SET_FEATURE) ||
				(r == RQ_SET_INTERFACE);
			8'h02: ok = (r == RQ_CLEAR_FEATURE) || (r == RQ_SET_FEATURE);
			8'h80: ok = (r == RQ_GET_CONFIG) || (r == RQ_GET_DESCRIPTOR) ||
				(r == RQ_GET_STATUS);
			8'h81: ok = (r == RQ_GET_INTERFACE) || (r == RQ_GET_STATUS);
			8'h82: ok = (r == RQ_GET_STATUS) || (r == RQ_SYNCH_FRAME);
			8'h20: ok = (r == RQ_CLEAR_FEATURE) || (r == RQ_SET_DESCRIPTOR) ||
				(r == RQ_SET_FEATURE);
			8'hA3: ok = (r == RQ_GET_STATE);
			8'hA0: ok = (r == RQ_GET_STATUS);
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

FILE: hw/rtl/usb_root_hub_request_responder.sv
// ----------------------------------------------------------------------------
// usb_root_hub_request_responder
// Answers hub control requests for a two-port UHCI root hub: port register
// writes, port status bytes and the hub descriptor.
// ----------------------------------------------------------------------------
// One request word enters an input register and is answered from there, one
// result word per cycle into an output register while the sink accepts; a
// request holds the input stage until its last result leaves, and it has 1
// result for most requests, 2 for SetPortFeature reset, 4 for GetPortStatus
// and 9 for GetHubDescriptor. The next request is taken in the same cycle as
// the last result of the current one leaves the input stage, so with a ready
// sink back-to-back single-result requests run at one per cycle. The output
// register decouples the sink, and output stalls hold the input stage.
module usb_root_hub_request_responder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// request_type, request_code, feature_value, port_index, port_status_in
	input  logic [usbrh_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// port_number, port_value, reply_byte, reply_length
	output logic [usbrh_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// port_write, reply_valid, request_error
	output logic [usbrh_pkg::M_TUSER_W-1:0]     m_axis_tuser,
	output logic                                m_axis_tlast
);
	import usbrh_pkg::*;

	logic              valid_s1;
	logic [7:0]        type_s1;
	logic [7:0]        code_s1;
	logic [15:0]       feat_s1;
	logic              port_s1;
	logic [15:0]       ps_s1;
	logic [IDX_W-1:0]  idx_q;

	logic              m_valid_q;
	result_t           res_q;

	logic [2:0]        kind;
	logic [IDX_W-1:0]  last_idx;
	logic              is_last;
	logic              advance;
	logic              accept;
	result_t           res;
	logic [15:0]       wr_val;
	logic [7:0]        stat_byte;

	always_comb begin
		if (type_s1 == RT_PORT_CLASS && code_s1 == RQ_CLEAR_FEATURE) begin
			kind = KIND_CLR;
		end else if (type_s1 == RT_PORT_CLASS && code_s1 == RQ_SET_FEATURE) begin
			kind = KIND_SET;
		end else if (type_s1 == RT_HUB_READ && code_s1 == RQ_GET_DESCRIPTOR) begin
			kind = KIND_DESC;
		end else if (type_s1 == RT_PORT_READ && code_s1 == RQ_GET_STATUS) begin
			kind = KIND_STAT;
		end else if (is_nop(type_s1, code_s1)) begin
			kind = KIND_NOP;
		end else begin
			kind = KIND_ERR;
		end
	end

	always_comb begin
		case (kind)
			KIND_SET:  last_idx = (feat_s1 == FEAT_RESET) ? 4'd1 : 4'd0;
			KIND_DESC: last_idx = LEN_DESC - 4'd1;
			KIND_STAT: last_idx = LEN_STATUS - 4'd1;
			default:   last_idx = 4'd0;
		endcase
	end

	assign is_last = (idx_q == last_idx);

	always_comb begin
		wr_val = ps_s1;
		if (kind == KIND_CLR) begin
			case (feat_s1)
				FEAT_ENABLE:      wr_val = ps_s1 & ~BIT_PED & WC_MASK;
				FEAT_SUSPEND:     wr_val = ps_s1 & ~BIT_SUSP & WC_MASK;
				FEAT_CONN_CHANGE: wr_val = (ps_s1 & WC_MASK) | BIT_CSC;
				FEAT_EN_CHANGE:   wr_val = (ps_s1 & WC_MASK) | BIT_PEDC;
				default:          wr_val = ps_s1;
			endcase
		end else begin
			case (feat_s1)
				FEAT_RESET: begin
					if (idx_q == 4'd0) begin
						wr_val = (ps_s1 & WC_MASK) | BIT_PED | BIT_PR;
					end else begin
						wr_val = (ps_s1 & WC_MASK & ~BIT_PR) | BIT_PED;
					end
				end
				FEAT_SUSPEND: wr_val = (ps_s1 & WC_MASK) | BIT_SUSP;
				default:      wr_val = ps_s1;
			endcase
		end
	end

	// status low, status high, change low, change high
	always_comb begin
		case (idx_q)
			4'd0:    stat_byte = {3'b000, ps_s1[9], 1'b0, ps_s1[12], ps_s1[2], ps_s1[0]};
			4'd1:    stat_byte = {6'b000000, ps_s1[8], 1'b1};
			4'd2:    stat_byte = {6'b000000, ps_s1[3], ps_s1[1]};
			default: stat_byte = 8'h00;
		endcase
	end

	always_comb begin
		res = '0;
		res.last_result = is_last;
		case (kind)
			KIND_CLR, KIND_SET: begin
				res.port_write  = 1'b1;
				res.port_number = port_s1;
				res.port_value  = wr_val;
			end
			KIND_DESC: begin
				res.reply_valid  = 1'b1;
				res.reply_byte   = hub_desc_byte(idx_q);
				res.reply_length = LEN_DESC;
			end
			KIND_STAT: begin
				res.reply_valid  = 1'b1;
				res.reply_byte   = stat_byte;
				res.reply_length = LEN_STATUS;
			end
			KIND_ERR: begin
				res.request_error = 1'b1;
			end
			default: begin
				res.request_error = 1'b0;
			end
		endcase
	end

	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || (advance && is_last);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance && is_last) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				idx_q <= is_last ? '0 : idx_q + 4'd1;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1 <= s_axis_tdata[7:0];
			code_s1 <= s_axis_tdata[15:8];
			feat_s1 <= s_axis_tdata[31:16];
			port_s1 <= s_axis_tdata[32];
			ps_s1   <= s_axis_tdata[48:33];
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.reply_length, res_q.reply_byte,
		res_q.port_value, res_q.port_number};
	assign m_axis_tuser  = {res_q.request_error, res_q.reply_valid, res_q.port_write};
	assign m_axis_tlast  = res_q.last_result;

endmodule
